// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/sacf_pkg.sv -----
// ----------------------------------------------------------------------------
// sacf_pkg
// Shared constants and types of the set-associative FIFO tag unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sacf_pkg;

    localparam int SETS          = 64;
    localparam int SET_BITS      = $clog2(SETS);
    localparam int WAYS_DEF      = 4;
    localparam int ADDR_BITS_DEF = 32;
    localparam int ADDR_W        = 32;
    localparam int WAY_OUT_W     = 2;
    localparam int OUT_W         = 40;

    typedef struct packed {
        logic accept;
        logic fire;
    } sacf_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } sacf_state_t;

endpackage

`default_nettype wire

// ----- sv/set_assoc_cache_fifo_tags_unit.sv -----
// A result beat turns valid when the lookup state fires the result register;
// the lookup, taking no new address, waits while the output is stalled. The
// tag row is read on accept and written back on a miss, via one memory port.
// A new address is taken while the previous result still waits at the output.
// Reset clears the valid bits and the sequencer; no clearing pass is needed.
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_tags_unit
// Tag store of a set-associative cache with FIFO replacement per set.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_fifo_tags_unit
    import sacf_pkg::*;
#(
    parameter int WAYS      = WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ADDR_W-1:0] s_tdata,   // address[31:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata    // hit, way_used[1:0], evicted,
                                              // evicted_address[31:0], pad
);

    sacf_cmd_t             cmd;
    logic                  hit;
    logic [WAY_OUT_W-1:0]  way_used;
    logic                  evicted;
    logic [ADDR_W-1:0]     evicted_address;

    sacf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sacf_dpath #(
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .address         (s_tdata),
        .hit             (hit),
        .way_used        (way_used),
        .evicted         (evicted),
        .evicted_address (evicted_address)
    );

    assign m_tdata = {{(OUT_W - ADDR_W - WAY_OUT_W - 2){1'b0}},
                      evicted_address, evicted, way_used, hit};

endmodule

`default_nettype wire

// ----- sv/sacf_ctrl.sv -----
// ----------------------------------------------------------------------------
// sacf_ctrl
// Access sequencer: accepts a beat, runs the lookup/write-back cycle and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sacf_ctrl
    import sacf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output sacf_cmd_t cmd
);

    sacf_state_t state_reg;
    sacf_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_comb
    begin
        cmd.accept     = 1'b0;
        cmd.fire       = 1'b0;
        s_tready       = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.fire       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    `ASSERT_NEXT(a_accept_to_look, clk, rst_n, cmd.accept, state_reg == S_LOOK)
    `ASSERT_NEXT(a_fire_loads_out, clk, rst_n, cmd.fire, out_valid_reg)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n,
        state_reg == S_LOOK && out_valid_reg && !m_tready, state_reg == S_LOOK)
    `ASSERT_SAME(a_no_overlap, clk, rst_n, cmd.accept, !cmd.fire)

endmodule

`default_nettype wire

// ----- sv/sacf_dpath.sv -----
// ----------------------------------------------------------------------------
// sacf_dpath
// Tag row memory, valid bits, tag compare, victim select and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sacf_dpath
    import sacf_pkg::*;
#(
    parameter int WAYS      = WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sacf_cmd_t         cmd,
    input  wire logic [ADDR_W-1:0] address,
    output logic                   hit,
    output logic [WAY_OUT_W-1:0]   way_used,
    output logic                   evicted,
    output logic [ADDR_W-1:0]      evicted_address
);

    localparam int AW    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TAG_W = AW - SET_BITS;
    localparam int PW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = PW + WAYS * TAG_W;

    logic [ROW_W-1:0]    mem [SETS];
    logic [WAYS-1:0]     valid_reg [SETS];
    logic [ROW_W-1:0]    row_reg;
    logic [AW-1:0]       addr_reg;

    logic [SET_BITS-1:0] idx;
    logic [TAG_W-1:0]    tag;
    logic [WAYS-1:0]     vrow;
    logic [PW-1:0]       ptr;
    logic [PW-1:0]       ptr_inc;
    logic                hit_c;
    logic [PW-1:0]       hit_way;
    logic [PW-1:0]       free_way;
    logic                full;
    logic [PW-1:0]       victim;
    logic [PW-1:0]       way_sel;
    logic [TAG_W-1:0]    old_tag;
    logic [ROW_W-1:0]    new_row;

    assign idx  = addr_reg[SET_BITS-1:0];
    assign tag  = addr_reg[AW-1:SET_BITS];
    assign vrow = valid_reg[idx];
    assign ptr  = row_reg[ROW_W-1 -: PW];
    assign full = &vrow;

    always_comb
    begin
        hit_c    = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vrow[w] && row_reg[w*TAG_W +: TAG_W] == tag)
            begin
                hit_c   = 1'b1;
                hit_way = PW'(w);
            end
            if (!vrow[w])
            begin
                free_way = PW'(w);
            end
        end
    end

    always_comb
    begin
        ptr_inc = (ptr == PW'(WAYS - 1)) ? '0 : ptr + 1'b1;
        victim  = full ? ptr : free_way;
        way_sel = hit_c ? hit_way : victim;
        old_tag = row_reg[victim*TAG_W +: TAG_W];
        new_row = row_reg;
        new_row[victim*TAG_W +: TAG_W] = tag;
        new_row[ROW_W-1 -: PW]         = full ? ptr_inc : '0;
    end

    // tag rows: read on accept, written back on a miss
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg  <= mem[address[SET_BITS-1:0]];
            addr_reg <= address[AW-1:0];
        end
        if (cmd.fire && !hit_c)
        begin
            mem[idx] <= new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else if (cmd.fire && !hit_c)
        begin
            valid_reg[idx][victim] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            hit             <= hit_c;
            way_used        <= WAY_OUT_W'(way_sel);
            evicted         <= !hit_c && full;
            evicted_address <= (!hit_c && full) ? ADDR_W'({old_tag, idx}) : '0;
        end
    end

endmodule

`default_nettype wire
